// ===== sv/twpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpm_pkg
// Shared types and constants for the token wildcard pattern matcher.
// ----------------------------------------------------------------------------
package twpm_pkg;

    localparam int TOKEN_SLOTS = 5;
    localparam int GRAM_SLOTS  = 5;
    localparam int WORD_BITS   = 22;
    localparam int LEN_BITS    = 3;
    localparam int KIND_BITS   = 2 * TOKEN_SLOTS;
    localparam int INDEX_BITS  = 3;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [LEN_BITS-1:0]  len_t;

    typedef enum logic [1:0] {
        KIND_LITERAL     = 2'd0,
        KIND_SINGLE      = 2'd1,
        KIND_STAR        = 2'd2,
        KIND_LITERAL_ALT = 2'd3
    } kind_t;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_TOKEN_KINDS    = 3'd1,
        REG_TOKEN_WORD_0   = 3'd2,
        REG_TOKEN_WORD_1   = 3'd3,
        REG_TOKEN_WORD_2   = 3'd4,
        REG_TOKEN_WORD_3   = 3'd5,
        REG_TOKEN_WORD_4   = 3'd6,
        REG_UNUSED         = 3'd7
    } reg_index_t;

    typedef struct packed {
        len_t                        pattern_length;
        logic [KIND_BITS-1:0]        token_kinds;
        logic [TOKEN_SLOTS-1:0][WORD_BITS-1:0] token_word;
    } cfg_t;

endpackage

// ===== sv/twpm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpm_cfg_regs
// Pattern register file. Token count is capped and word identifiers are
// trimmed to the compare width when written.
// ----------------------------------------------------------------------------
module twpm_cfg_regs #(
    parameter int TOKEN_CAP = 5,
    parameter int CMP_BITS  = 22
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [twpm_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [twpm_pkg::WORD_BITS-1:0]  cfg_data,
    output twpm_pkg::cfg_t                  cfg
);

    twpm_pkg::len_t                         pattern_length_reg;
    logic [twpm_pkg::KIND_BITS-1:0]         token_kinds_reg;
    twpm_pkg::len_t                         length_in;

    assign length_in = cfg_data[twpm_pkg::LEN_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            token_kinds_reg    <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == twpm_pkg::REG_PATTERN_LENGTH)
            begin
                if (length_in > twpm_pkg::LEN_BITS'(TOKEN_CAP))
                    pattern_length_reg <= twpm_pkg::LEN_BITS'(TOKEN_CAP);
                else
                    pattern_length_reg <= length_in;
            end
            if (cfg_index == twpm_pkg::REG_TOKEN_KINDS)
                token_kinds_reg <= cfg_data[twpm_pkg::KIND_BITS-1:0];
        end
    end

    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.token_kinds    = token_kinds_reg;

    for (genvar t = 0; t < twpm_pkg::TOKEN_SLOTS; t++)
    begin : g_word
        if (t < TOKEN_CAP)
        begin : g_live
            logic [CMP_BITS-1:0] word_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    word_reg <= '0;
                else if (cfg_write &&
                         cfg_index == twpm_pkg::INDEX_BITS'(twpm_pkg::REG_TOKEN_WORD_0 + t))
                    word_reg <= cfg_data[CMP_BITS-1:0];
            end

            assign cfg.token_word[t] = twpm_pkg::word_t'(word_reg);
        end
        else
        begin : g_dead
            assign cfg.token_word[t] = '0;
        end
    end

endmodule

// ===== sv/twpm_nfa.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpm_nfa
// Bit-parallel NFA over consumed word positions; one token per step.
// ----------------------------------------------------------------------------
module twpm_nfa (
    input  twpm_pkg::cfg_t                                     cfg,
    input  twpm_pkg::len_t                                     gram_length,
    input  logic [twpm_pkg::GRAM_SLOTS-1:0][twpm_pkg::WORD_BITS-1:0] gram_word,
    output logic                                               matched
);

    localparam int POS = twpm_pkg::GRAM_SLOTS + 1;

    always_comb
    begin
        logic [POS-1:0] reach;
        logic [POS-1:0] step;
        logic [POS-1:0] len_mask;
        logic           acc;
        twpm_pkg::kind_t kind;

        acc = 1'b0;
        for (int j = 0; j < POS; j++)
            len_mask[j] = (twpm_pkg::LEN_BITS'(j) <= gram_length);

        reach = POS'(1);
        for (int t = 0; t < twpm_pkg::TOKEN_SLOTS; t++)
        begin
            kind = twpm_pkg::kind_t'(cfg.token_kinds[2*t +: 2]);
            step = reach;
            if (twpm_pkg::LEN_BITS'(t) < cfg.pattern_length)
            begin
                step = '0;
                unique case (kind)
                    twpm_pkg::KIND_STAR:
                    begin
                        acc = 1'b0;
                        for (int j = 0; j < POS; j++)
                        begin
                            acc     = acc | reach[j];
                            step[j] = acc & len_mask[j];
                        end
                    end
                    twpm_pkg::KIND_SINGLE,
                    twpm_pkg::KIND_LITERAL,
                    twpm_pkg::KIND_LITERAL_ALT:
                    begin
                        for (int j = 0; j < twpm_pkg::GRAM_SLOTS; j++)
                            step[j+1] = reach[j] &&
                                        (twpm_pkg::LEN_BITS'(j) < gram_length) &&
                                        (kind == twpm_pkg::KIND_SINGLE ||
                                         gram_word[j] == cfg.token_word[t]);
                    end
                    default: step = '0;
                endcase
            end
            reach = step;
        end

        matched = 1'b0;
        for (int j = 0; j < POS; j++)
            if (gram_length == twpm_pkg::LEN_BITS'(j))
                matched = reach[j];
    end

endmodule

// ===== sv/token_wildcard_pattern_match.sv =====
`timescale 1ns / 1ps
// The result strobe (done) follows the start transfer through the input valid flag and then the done register.
// Throughput: one n-gram per cycle; input register, one NFA pass, result register.
// busy is always low, so start may be held high every cycle.
// Reset clears the pattern registers and the pipeline valid flags.
// The result is shown for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
// token_wildcard_pattern_match
// Matches an n-gram of word identifiers against a pattern of literal,
// single-word and star tokens.
// ----------------------------------------------------------------------------
module token_wildcard_pattern_match #(
    parameter int MAX_TOKENS   = 5,
    parameter int WORD_ID_BITS = 22
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [twpm_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [twpm_pkg::WORD_BITS-1:0]  cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [twpm_pkg::LEN_BITS-1:0]   gram_length,
    input  logic [twpm_pkg::WORD_BITS-1:0]  gram_word_0,
    input  logic [twpm_pkg::WORD_BITS-1:0]  gram_word_1,
    input  logic [twpm_pkg::WORD_BITS-1:0]  gram_word_2,
    input  logic [twpm_pkg::WORD_BITS-1:0]  gram_word_3,
    input  logic [twpm_pkg::WORD_BITS-1:0]  gram_word_4,
    output logic                            done,
    output logic                            matched
);

    localparam int TOKEN_CAP = (MAX_TOKENS < twpm_pkg::TOKEN_SLOTS) ?
                               MAX_TOKENS : twpm_pkg::TOKEN_SLOTS;
    localparam int CMP_BITS  = (WORD_ID_BITS < twpm_pkg::WORD_BITS) ?
                               WORD_ID_BITS : twpm_pkg::WORD_BITS;

    twpm_pkg::cfg_t  cfg;
    logic            in_valid_reg;
    twpm_pkg::len_t  in_length_reg;
    logic [twpm_pkg::GRAM_SLOTS-1:0][twpm_pkg::WORD_BITS-1:0] in_word_reg;
    logic [twpm_pkg::GRAM_SLOTS-1:0][twpm_pkg::WORD_BITS-1:0] in_word_next;
    logic            done_reg;
    logic            matched_reg;
    logic            matched_next;
    logic            accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_word_next[0] = twpm_pkg::word_t'(gram_word_0[CMP_BITS-1:0]);
    assign in_word_next[1] = twpm_pkg::word_t'(gram_word_1[CMP_BITS-1:0]);
    assign in_word_next[2] = twpm_pkg::word_t'(gram_word_2[CMP_BITS-1:0]);
    assign in_word_next[3] = twpm_pkg::word_t'(gram_word_3[CMP_BITS-1:0]);
    assign in_word_next[4] = twpm_pkg::word_t'(gram_word_4[CMP_BITS-1:0]);

    twpm_cfg_regs #(
        .TOKEN_CAP (TOKEN_CAP),
        .CMP_BITS  (CMP_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_length_reg <= gram_length;
            in_word_reg   <= in_word_next;
        end
        if (in_valid_reg)
            matched_reg <= matched_next;
    end

    twpm_nfa u_nfa (
        .cfg         (cfg),
        .gram_length (in_length_reg),
        .gram_word   (in_word_reg),
        .matched     (matched_next)
    );

    assign done    = done_reg;
    assign matched = matched_reg;

endmodule
